// ===== hdl/hbp_pkg.sv =====
// Shared types and constants of the Huffman bit packer.
package hbp_pkg;

  localparam int SYMBOL_COUNT = 128;
  localparam int MAX_CODE_LEN = 32;
  localparam int VALUE_BITS   = 32;
  localparam int SYM_W        = 7;
  localparam int LEN_W        = 6;
  localparam int TBL_AW       = $clog2(SYMBOL_COUNT);
  localparam int FIFO_DEPTH   = 4;

  localparam logic [1:0] REQ_LOAD   = 2'd0;
  localparam logic [1:0] REQ_ENCODE = 2'd1;
  localparam logic [1:0] REQ_FLUSH  = 2'd2;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_NO_CODE = 2'd1;
  localparam logic [1:0] STATUS_BAD_LEN = 2'd2;

  typedef enum logic [1:0] {
    CMD_ENCODE,
    CMD_FLUSH,
    CMD_ERR_SYM,
    CMD_ERR_LEN
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t              kind;
    logic [VALUE_BITS-1:0]  value;
    logic [LEN_W-1:0]       len;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

// ===== hdl/huffman_bit_packer_unit.sv =====
// Path: an item's table read and classification are registered at the accepting edge, then
// it passes the queue, the command register and the result register; an encode emits a byte
// only when a full accumulator meets a further code bit, a flush only when bits are held.
// Throughput: the front takes one item a cycle into a 4-entry queue while it is not full;
// the back shifts each code in by chunks that fit the accumulator and waits on m_tready.
// Reset (rst, sync) clears the table's valid bits at once, accumulator, queue and m_tvalid.
module huffman_bit_packer_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // symbol[6:0], code_value[38:7], code_length[44:39], zeros
  input  logic [1:0]  s_tuser,   // req_type[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // out_byte[7:0]
  output logic [1:0]  m_tuser,   // status[1:0]
  output logic        m_tlast
);

  hbp_pkg::fifo_stat_t fifo_stat;
  hbp_pkg::cmd_t       push_cmd;
  hbp_pkg::cmd_t       head;
  logic                push;
  logic                pop;

  hbp_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .req_type    (s_tuser),
    .symbol      (s_tdata[6:0]),
    .code_value  (s_tdata[38:7]),
    .code_length (s_tdata[44:39]),
    .fifo_stat   (fifo_stat),
    .push        (push),
    .push_cmd    (push_cmd)
  );

  hbp_cmd_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .stat     (fifo_stat)
  );

  hbp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .fifo_stat (fifo_stat),
    .pop       (pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_byte  (m_tdata),
    .status    (m_tuser),
    .last      (m_tlast)
  );

endmodule

// ===== hdl/hbp_front.sv =====
// Front end: accepts items, owns the code table, queues encode, flush, bad-load commands.
module hbp_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  req_type,
  input  logic [hbp_pkg::SYM_W-1:0]   symbol,
  input  logic [hbp_pkg::VALUE_BITS-1:0] code_value,
  input  logic [hbp_pkg::LEN_W-1:0]   code_length,
  input  hbp_pkg::fifo_stat_t         fifo_stat,
  output logic                        push,
  output hbp_pkg::cmd_t               push_cmd
);

  localparam int AW = hbp_pkg::TBL_AW;
  localparam int EW = hbp_pkg::LEN_W + hbp_pkg::VALUE_BITS;

  logic [EW-1:0]                      tbl_mem [hbp_pkg::SYMBOL_COUNT];
  logic [hbp_pkg::SYMBOL_COUNT-1:0]   tbl_valid;

  logic                               s1_valid;
  hbp_pkg::cmd_kind_t                 s1_kind;
  logic [EW-1:0]                      rd_entry;
  logic                               rd_hit;

  logic                               accept;
  logic                               in_range;
  logic                               bad_len;
  logic                               has_cmd;
  logic [AW-1:0]                      idx;

  assign in_ready = !s1_valid || !fifo_stat.full;
  assign accept   = in_valid && in_ready;
  assign in_range = (int'(symbol) < hbp_pkg::SYMBOL_COUNT);
  assign idx      = AW'(symbol);
  assign bad_len  = (code_length == '0) || (int'(code_length) > hbp_pkg::MAX_CODE_LEN) ||
                    (int'(code_length) > hbp_pkg::VALUE_BITS);
  // items that hand a command to the back end
  assign has_cmd  = (req_type inside {hbp_pkg::REQ_ENCODE, hbp_pkg::REQ_FLUSH}) ||
                    (req_type == hbp_pkg::REQ_LOAD && bad_len);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      tbl_valid <= '0;
    end else begin
      if (accept && has_cmd) begin
        s1_valid <= 1'b1;
      end else if (s1_valid && !fifo_stat.full) begin
        s1_valid <= 1'b0;
      end
      if (accept && req_type == hbp_pkg::REQ_LOAD && !bad_len && in_range) begin
        tbl_valid[idx] <= 1'b1;
      end
    end
  end

  // table port and classification data; no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      case (req_type)
        hbp_pkg::REQ_LOAD: begin
          s1_kind <= hbp_pkg::CMD_ERR_LEN;
          if (!bad_len && in_range) begin
            tbl_mem[idx] <= {code_length, code_value};
          end
        end
        hbp_pkg::REQ_ENCODE: begin
          s1_kind  <= hbp_pkg::CMD_ENCODE;
          rd_entry <= tbl_mem[idx];
          rd_hit   <= in_range && tbl_valid[idx];
        end
        hbp_pkg::REQ_FLUSH: s1_kind <= hbp_pkg::CMD_FLUSH;
        default: ;
      endcase
    end
  end

  always_comb begin
    push           = s1_valid && !fifo_stat.full;
    push_cmd.kind  = (s1_kind == hbp_pkg::CMD_ENCODE && !rd_hit) ? hbp_pkg::CMD_ERR_SYM
                                                                  : s1_kind;
    push_cmd.value = rd_entry[hbp_pkg::VALUE_BITS-1:0];
    push_cmd.len   = rd_entry[EW-1:hbp_pkg::VALUE_BITS];
  end

endmodule

// ===== hdl/hbp_cmd_fifo.sv =====
// Short command queue between the front end and the bit packing back end.
module hbp_cmd_fifo (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  hbp_pkg::cmd_t       push_cmd,
  input  logic                pop,
  output hbp_pkg::cmd_t       head,
  output hbp_pkg::fifo_stat_t stat
);

  localparam int PW = $clog2(hbp_pkg::FIFO_DEPTH);
  localparam int CW = $clog2(hbp_pkg::FIFO_DEPTH + 1);

  hbp_pkg::cmd_t  entries [hbp_pkg::FIFO_DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;

  assign stat.full  = (int'(count) == hbp_pkg::FIFO_DEPTH);
  assign stat.empty = (count == '0);
  assign head       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (int'(wr_ptr) == hbp_pkg::FIFO_DEPTH - 1) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (int'(rd_ptr) == hbp_pkg::FIFO_DEPTH - 1) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

// ===== hdl/hbp_back.sv =====
// Back end: shifts code bits into the byte accumulator and drives the result register.
module hbp_back (
  input  logic                clk,
  input  logic                rst,
  input  hbp_pkg::cmd_t       head,
  input  hbp_pkg::fifo_stat_t fifo_stat,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          out_byte,
  output logic [1:0]          status,
  output logic                last
);

  logic [7:0]                     acc, acc_next;
  logic [3:0]                     held, held_next;
  logic                           cur_valid, cur_valid_next;
  hbp_pkg::cmd_kind_t             cur_kind, cur_kind_next;
  logic [hbp_pkg::VALUE_BITS-1:0] sr, sr_next;
  logic [hbp_pkg::LEN_W-1:0]      rem, rem_next;

  logic        ofree;
  logic        done;
  logic        emit;
  logic [7:0]  emit_byte;
  logic [1:0]  emit_status;
  logic        emit_last;
  logic [3:0]  space;
  logic [3:0]  k;
  logic [7:0]  chunk;
  logic [15:0] acc_shift;

  assign ofree     = !out_valid || out_ready;
  assign space     = (held == 4'd8) ? 4'd8 : 4'd8 - held;
  assign k         = (rem < {2'b00, space}) ? rem[3:0] : space;
  // top k pending code bits, right-aligned
  assign chunk     = sr[hbp_pkg::VALUE_BITS-1 -: 8] >> (4'd8 - k);
  assign acc_shift = {8'h00, acc} << k;

  always_comb begin
    acc_next       = acc;
    held_next      = held;
    cur_valid_next = cur_valid;
    cur_kind_next  = cur_kind;
    sr_next        = sr;
    rem_next       = rem;
    done           = 1'b0;
    emit           = 1'b0;
    emit_byte      = 8'h00;
    emit_status    = hbp_pkg::STATUS_OK;
    emit_last      = 1'b1;
    pop            = 1'b0;

    if (cur_valid) begin
      case (cur_kind)
        hbp_pkg::CMD_ENCODE: begin
          if (held == 4'd8) begin
            // full byte goes out only now that another bit arrives
            if (ofree) begin
              emit      = 1'b1;
              emit_byte = acc;
              emit_last = (rem == {2'b00, k});
              acc_next  = chunk;
              held_next = k;
              sr_next   = sr << k;
              rem_next  = rem - {2'b00, k};
              done      = (rem == {2'b00, k});
            end
          end else begin
            acc_next  = acc_shift[7:0] | chunk;
            held_next = held + k;
            sr_next   = sr << k;
            rem_next  = rem - {2'b00, k};
            done      = (rem == {2'b00, k});
          end
        end
        hbp_pkg::CMD_FLUSH: begin
          if (held == 4'd0) begin
            done = 1'b1;
          end else if (ofree) begin
            emit      = 1'b1;
            emit_byte = acc << (4'd8 - held);
            acc_next  = 8'h00;
            held_next = 4'd0;
            done      = 1'b1;
          end
        end
        hbp_pkg::CMD_ERR_SYM: begin
          if (ofree) begin
            emit        = 1'b1;
            emit_status = hbp_pkg::STATUS_NO_CODE;
            done        = 1'b1;
          end
        end
        hbp_pkg::CMD_ERR_LEN: begin
          if (ofree) begin
            emit        = 1'b1;
            emit_status = hbp_pkg::STATUS_BAD_LEN;
            done        = 1'b1;
          end
        end
        default: done = 1'b1;
      endcase
    end

    if ((!cur_valid || done) && !fifo_stat.empty) begin
      pop            = 1'b1;
      cur_valid_next = 1'b1;
      cur_kind_next  = head.kind;
      // left-align the code so the next bit sits in the top position
      sr_next        = head.value << (hbp_pkg::LEN_W'(hbp_pkg::VALUE_BITS) - head.len);
      rem_next       = head.len;
    end else if (done) begin
      cur_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= 8'h00;
      held      <= 4'd0;
      cur_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      acc       <= acc_next;
      held      <= held_next;
      cur_valid <= cur_valid_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_kind <= cur_kind_next;
    sr       <= sr_next;
    rem      <= rem_next;
    if (emit) begin
      out_byte <= emit_byte;
      status   <= emit_status;
      last     <= emit_last;
    end
  end

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for huffman_bit_packer_unit: stream stimulus, bit-packing predictor.
module tb_top;

  localparam int IDLE_LIMIT = 1000;
  localparam int TAIL_CYCLES = 20;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  typedef logic [hbp_pkg::SYM_W-1:0] sym_t;
  typedef logic [hbp_pkg::LEN_W-1:0] len_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] status;
    logic       last;
  } packed_byte_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;

  // packer model state
  logic [hbp_pkg::VALUE_BITS-1:0] code_bits [hbp_pkg::SYMBOL_COUNT];
  len_t                           code_len [hbp_pkg::SYMBOL_COUNT];
  logic [7:0]                     acc_bits = '0;
  int unsigned                    acc_count = 0;

  packed_byte_t expected_bytes [$];
  packed_byte_t step_bytes [$];
  int          errors = 0;
  int          idle_cycles = 0;
  bit          tx_gaps = 1'b0;
  bit          rx_stalls = 1'b0;
  int          rx_hold = 0;

  huffman_bit_packer_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always #5 clk = ~clk;

  initial begin
    for (int i = 0; i < hbp_pkg::SYMBOL_COUNT; i++) begin
      code_bits[i] = '0;
      code_len[i] = '0;
    end
  end

  function automatic int pick_gap();
    if ($urandom_range(0, 9) == 0) return $urandom_range(15, 40);
    return $urandom_range(1, 3);
  endfunction

  function automatic len_t pick_len();
    if ($urandom_range(0, 7) == 0) return len_t'($urandom_range(9, hbp_pkg::MAX_CODE_LEN));
    return len_t'($urandom_range(1, 8));
  endfunction

  // A full byte leaves only when the next bit shows up.
  task automatic shift_code_bit(input logic b);
    if (acc_count >= 8) begin
      step_bytes.push_back('{acc_bits, hbp_pkg::STATUS_OK, 1'b0});
      acc_bits = '0;
      acc_count = 0;
    end
    acc_bits = {acc_bits[6:0], b};
    acc_count++;
  endtask

  task automatic pack_request(input logic [1:0] req, input sym_t sym,
                              input logic [hbp_pkg::VALUE_BITS-1:0] val, input len_t len);
    int unsigned clen;
    logic [hbp_pkg::VALUE_BITS-1:0] cval;
    packed_byte_t r;
    step_bytes.delete();
    case (req)
      hbp_pkg::REQ_LOAD: begin
        if (len == 0 || len > hbp_pkg::MAX_CODE_LEN || len > hbp_pkg::VALUE_BITS) begin
          step_bytes.push_back('{8'h00, hbp_pkg::STATUS_BAD_LEN, 1'b0});
        end else if (sym < hbp_pkg::SYMBOL_COUNT) begin
          code_bits[sym] = val;
          code_len[sym] = len;
        end
      end
      hbp_pkg::REQ_ENCODE: begin
        clen = 0;
        cval = '0;
        if (sym < hbp_pkg::SYMBOL_COUNT) begin
          clen = 32'(code_len[sym]);
          cval = code_bits[sym];
        end
        if (clen == 0 || clen > hbp_pkg::VALUE_BITS) begin
          step_bytes.push_back('{8'h00, hbp_pkg::STATUS_NO_CODE, 1'b0});
        end else begin
          for (int k = clen - 1; k >= 0; k--) shift_code_bit(cval[k]);
        end
      end
      hbp_pkg::REQ_FLUSH: begin
        if (acc_count > 0) begin
          step_bytes.push_back('{8'(acc_bits << (8 - acc_count)), hbp_pkg::STATUS_OK, 1'b0});
          acc_bits = '0;
          acc_count = 0;
        end
      end
      default: ;
    endcase
    for (int i = 0; i < step_bytes.size(); i++) begin
      r = step_bytes[i];
      r.last = (i == step_bytes.size() - 1);
      expected_bytes.push_back(r);
    end
  endtask

  // Predict on each accepted item, check each accepted result, track idle cycles.
  always @(posedge clk) begin
    packed_byte_t exp_r;
    if (!rst) begin
      if (s_tvalid && s_tready)
        pack_request(s_tuser, s_tdata[6:0], s_tdata[38:7], s_tdata[44:39]);
      if (m_tvalid && m_tready) begin
        if (expected_bytes.size() == 0) begin
          $error("result with none pending: out_byte %0h status %0d last %0b",
                 m_tdata, m_tuser, m_tlast);
          errors++;
        end else begin
          exp_r = expected_bytes.pop_front();
          if (m_tdata !== exp_r.out_byte) begin
            $error("out_byte: expected %0h, got %0h", exp_r.out_byte, m_tdata);
            errors++;
          end
          if (m_tuser !== exp_r.status) begin
            $error("status: expected %0d, got %0d", exp_r.status, m_tuser);
            errors++;
          end
          if (m_tlast !== exp_r.last) begin
            $error("last: expected %0b, got %0b", exp_r.last, m_tlast);
            errors++;
          end
        end
      end
    end
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  // Receiver back-pressure.
  always @(posedge clk) begin
    if (rx_hold > 0) begin
      rx_hold <= rx_hold - 1;
      m_tready <= 1'b0;
    end else if (rx_stalls && $urandom_range(0, 3) == 0) begin
      rx_hold <= pick_gap() - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  task automatic send_item(input logic [1:0] req, input sym_t sym,
                           input logic [hbp_pkg::VALUE_BITS-1:0] val, input len_t len);
    int gap;
    s_tdata <= {3'b000, len, val, sym};
    s_tuser <= req;
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (tx_gaps && $urandom_range(0, 3) == 0) begin
      gap = pick_gap();
      s_tvalid <= 1'b0;
      s_tdata <= 48'({$urandom, $urandom});
      s_tuser <= 2'($urandom_range(0, 3));
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic tx_quiet();
    s_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    tx_quiet();
    while (expected_bytes.size() != 0) @(posedge clk);
  endtask

  // Reset state: nothing loaded, flush with empty accumulator, unknown request.
  task automatic test_empty_table();
    send_item(hbp_pkg::REQ_ENCODE, 7'd0, 32'h0, 6'd0);
    send_item(hbp_pkg::REQ_ENCODE, 7'd127, 32'hFFFF_FFFF, 6'd63);
    send_item(hbp_pkg::REQ_FLUSH, 7'd0, 32'h0, 6'd0);
    send_item(REQ_UNUSED, 7'd127, 32'hFFFF_FFFF, 6'd63);
  endtask

  task automatic test_bad_length();
    send_item(hbp_pkg::REQ_LOAD, 7'd9, 32'h1, 6'd0);
    send_item(hbp_pkg::REQ_LOAD, 7'd9, 32'h1, 6'd33);
    send_item(hbp_pkg::REQ_LOAD, 7'd9, 32'hFFFF_FFFF, 6'd63);
    send_item(hbp_pkg::REQ_ENCODE, 7'd9, 32'h0, 6'd0);
  endtask

  task automatic test_code_extremes();
    send_item(hbp_pkg::REQ_LOAD, 7'd127, 32'hFFFF_FFFF, 6'd32);
    send_item(hbp_pkg::REQ_LOAD, 7'd0, 32'h0, 6'd1);
    send_item(hbp_pkg::REQ_LOAD, 7'd5, 32'h0000_00A5, 6'd8);
    send_item(hbp_pkg::REQ_ENCODE, 7'd127, 32'h0, 6'd0);
    // accumulator full, so a 32-bit code yields four bytes
    send_item(hbp_pkg::REQ_ENCODE, 7'd127, 32'h0, 6'd0);
    send_item(hbp_pkg::REQ_FLUSH, 7'd0, 32'h0, 6'd0);
    send_item(hbp_pkg::REQ_ENCODE, 7'd0, 32'h0, 6'd0);
    send_item(hbp_pkg::REQ_ENCODE, 7'd5, 32'h0, 6'd0);
    send_item(hbp_pkg::REQ_FLUSH, 7'd0, 32'h0, 6'd0);
    send_item(hbp_pkg::REQ_LOAD, 7'd5, 32'h0000_0003, 6'd2);
    send_item(hbp_pkg::REQ_ENCODE, 7'd5, 32'h0, 6'd0);
    send_item(hbp_pkg::REQ_FLUSH, 7'd0, 32'h0, 6'd0);
  endtask

  // Hold the sender until every pending byte is out, under receiver stalls.
  task automatic test_drain_pause();
    rx_stalls = 1'b1;
    for (int i = 0; i < 6; i++) send_item(hbp_pkg::REQ_ENCODE, 7'd127, $urandom, len_t'($urandom));
    wait_drained();
    send_item(hbp_pkg::REQ_FLUSH, 7'd0, 32'h0, 6'd0);
    rx_stalls = 1'b0;
  endtask

  task automatic test_random_stream();
    int sent;
    int pick;
    for (int s = 0; s < 16; s++) send_item(hbp_pkg::REQ_LOAD, sym_t'(s), $urandom, pick_len());
    sent = 16;
    while (sent < 175) begin
      if (sent % 50 == 0) begin
        tx_gaps = 1'($urandom_range(0, 1));
        rx_stalls = 1'($urandom_range(0, 1));
      end
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        send_item(hbp_pkg::REQ_LOAD,
                  sym_t'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 127)
                                                     : $urandom_range(0, 15)),
                  $urandom, pick_len());
      end else if (pick < 11) begin
        send_item(hbp_pkg::REQ_LOAD, sym_t'($urandom_range(0, 127)), $urandom,
                  $urandom_range(0, 1) ? 6'd0 : len_t'($urandom_range(33, 63)));
      end else if (pick < 15) begin
        send_item(hbp_pkg::REQ_FLUSH, sym_t'($urandom), $urandom, len_t'($urandom));
      end else if (pick < 17) begin
        send_item(REQ_UNUSED, sym_t'($urandom), $urandom, len_t'($urandom));
        continue;
      end else if (pick < 20) begin
        send_item(hbp_pkg::REQ_ENCODE, sym_t'($urandom_range(0, 127)), $urandom,
                  len_t'($urandom));
      end else begin
        send_item(hbp_pkg::REQ_ENCODE, sym_t'($urandom_range(0, 15)), $urandom,
                  len_t'($urandom));
      end
      sent++;
    end
    tx_gaps = 1'b0;
    rx_stalls = 1'b0;
    send_item(hbp_pkg::REQ_FLUSH, 7'd0, 32'h0, 6'd0);
  endtask

  initial begin
    wait (idle_cycles >= IDLE_LIMIT);
    $display("huffman_bit_packer_unit regression: fail");
    $finish;
  end

  initial begin
    rst <= 1'b1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_table();
    test_bad_length();
    test_code_extremes();
    test_drain_pause();
    test_random_stream();
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0 && expected_bytes.size() == 0) begin
      $display("huffman_bit_packer_unit regression: pass");
    end else begin
      $display("huffman_bit_packer_unit regression: fail");
    end
    $finish;
  end

endmodule
